/* src/monod_growth_midpoint_integrator_macros.svh */
// Assertion macros for the Monod growth midpoint integrator.
`ifndef MONOD_GROWTH_MIDPOINT_INTEGRATOR_MACROS_SVH
`define MONOD_GROWTH_MIDPOINT_INTEGRATOR_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define MGMI_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define MGMI_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* src/mgmi_pkg.sv */
// ----------------------------------------------------------------------------
// mgmi_pkg
// Types, constants and command codes shared by the Monod integrator modules.
// ----------------------------------------------------------------------------
package mgmi_pkg;

	localparam int unsigned DefMaxSubsteps = 1024;
	localparam int unsigned DefFracBits = 20;
	localparam int unsigned DataW = 32;
	localparam int unsigned RegW = 31;
	localparam int unsigned StepW = 11;
	localparam int unsigned NumRegs = 8;
	localparam int unsigned AddrW = 5;

	// Register indexes.
	localparam logic [2:0] RegTimeStep = 3'd0;
	localparam logic [2:0] RegBioYield = 3'd1;
	localparam logic [2:0] RegProdYield = 3'd2;
	localparam logic [2:0] RegOxyYield = 3'd3;
	localparam logic [2:0] RegCapacity = 3'd4;
	localparam logic [2:0] RegMaxUptake = 3'd5;
	localparam logic [2:0] RegOxyHalf = 3'd6;
	localparam logic [2:0] RegSubHalf = 3'd7;

	localparam logic [RegW-1:0] RstTimeStep = 31'd10486;
	localparam logic [RegW-1:0] RstBioYield = 31'd50381;
	localparam logic [RegW-1:0] RstProdYield = 31'd331168;
	localparam logic [RegW-1:0] RstOxyYield = 31'd208990;
	localparam logic [RegW-1:0] RstCapacity = 31'd8283750;
	localparam logic [RegW-1:0] RstMaxUptake = 31'd4719550;
	localparam logic [RegW-1:0] RstOxyHalf = 31'd14512;
	localparam logic [RegW-1:0] RstSubHalf = 31'd965212;

	typedef struct packed {
		logic signed [31:0] biomass_in;
		logic signed [31:0] oxygen_in;
		logic signed [31:0] substrate_in;
		logic signed [31:0] product_in;
		logic [10:0] step_count;
	} req_t;

	typedef struct packed {
		logic signed [31:0] biomass_out;
		logic signed [31:0] substrate_out;
		logic signed [31:0] product_out;
		logic signed [31:0] oxygen_uptake;
	} rsp_t;

	typedef struct packed {
		logic [RegW-1:0] time_step;
		logic [RegW-1:0] biomass_yield;
		logic [RegW-1:0] product_yield;
		logic [RegW-1:0] oxygen_yield;
		logic [RegW-1:0] biomass_capacity;
		logic [RegW-1:0] max_uptake;
		logic [RegW-1:0] oxygen_half_saturation;
		logic [RegW-1:0] substrate_half_saturation;
	} cfg_t;

	// Datapath register file slots.
	typedef enum logic [3:0] {
		R_X, R_O, R_G, R_M, R_XH, R_GH, R_MH, R_Q,
		R_T0, R_T1, R_RX, R_RG, R_RM, R_OUR
	} reg_id_t;

	// Operand sources: register file slots, configuration values or the constant one.
	typedef enum logic [4:0] {
		S_X, S_O, S_G, S_M, S_XH, S_GH, S_MH, S_Q,
		S_T0, S_T1, S_RX, S_RG, S_RM, S_OUR,
		S_DT, S_BY, S_PY, S_OY, S_CAP, S_QMAX, S_KO, S_KS, S_ONE
	} src_t;

	typedef enum logic [2:0] {
		OP_LOAD, OP_ADD, OP_SUB, OP_ADDHALF, OP_NEG, OP_MUL, OP_DIV
	} op_t;

	typedef struct packed {
		logic start;
		op_t op;
		src_t a;
		src_t b;
		reg_id_t dst;
		logic load_in;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic busy;
	} sts_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

/* src/mgmi_datapath.sv */
// ----------------------------------------------------------------------------
// mgmi_datapath
// Register file, adder, multi-cycle multiplier and restoring divider.
// ----------------------------------------------------------------------------
module mgmi_datapath
	import mgmi_pkg::*;
#(
	parameter int unsigned FRAC_BITS = DefFracBits
) (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	input req_t req,
	input cfg_t cfg,
	output sts_t sts,
	output rsp_t rsp
);

	localparam int unsigned QW = 32 + FRAC_BITS + 1;
	localparam int unsigned CW = $clog2(QW + 1);

	logic signed [31:0] rf_q [14];
	logic signed [31:0] opa, opb, res;
	op_t op_q;
	reg_id_t dst_q;
	logic busy_q;
	logic [CW-1:0] cnt_q;
	logic signed [63:0] prod_q;
	logic [1:0] mph_q;
	logic [QW-1:0] num_q, quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic neg_q, dz_q;
	logic signed [31:0] a_q, b_q;

	// Operand selection.
	function automatic logic signed [31:0] pick(input src_t s);
		logic signed [31:0] v;
		v = '0;
		case (s)
			S_DT: v = {1'b0, cfg.time_step};
			S_BY: v = {1'b0, cfg.biomass_yield};
			S_PY: v = {1'b0, cfg.product_yield};
			S_OY: v = {1'b0, cfg.oxygen_yield};
			S_CAP: v = {1'b0, cfg.biomass_capacity};
			S_QMAX: v = {1'b0, cfg.max_uptake};
			S_KO: v = {1'b0, cfg.oxygen_half_saturation};
			S_KS: v = {1'b0, cfg.substrate_half_saturation};
			S_ONE: v = 32'sd1 <<< FRAC_BITS;
			default: v = rf_q[s[3:0]];
		endcase
		return v;
	endfunction

	// The operands follow both the command and the register file contents.
	always_comb begin
		opa = pick(cmd.a);
		opb = pick(cmd.b);
	end

	// Combinational adder results.
	always_comb begin
		case (cmd.op)
			OP_LOAD: res = opa;
			OP_ADD: res = sat32(66'(opa) + 66'(opb));
			OP_SUB: res = sat32(66'(opa) - 66'(opb));
			OP_ADDHALF: res = sat32(66'(opa) + 66'(opb / 2));
			OP_NEG: res = sat32(-66'(opa));
			default: res = '0;
		endcase
	end

	// Multiply (16x32 partial products) and divide (one quotient bit a cycle).
	logic signed [65:0] mfull;
	logic [65:0] mmag;
	logic signed [65:0] mq;
	logic [32:0] rsh;
	assign mfull = 66'(prod_q);
	assign mmag = mfull[65] ? 66'(-mfull) : mfull;
	assign mq = mfull[65] ? -66'(mmag >> FRAC_BITS) : 66'(mmag >> FRAC_BITS);
	assign rsh = {rem_q[31:0], num_q[QW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.start) begin
			busy_q <= (cmd.op == OP_MUL) || (cmd.op == OP_DIV);
		end else if (busy_q) begin
			if (op_q == OP_MUL && mph_q == 2'd2) busy_q <= 1'b0;
			if (op_q == OP_DIV && cnt_q == '0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			rf_q[R_X] <= req.biomass_in;
			rf_q[R_O] <= req.oxygen_in;
			rf_q[R_G] <= req.substrate_in;
			rf_q[R_M] <= req.product_in;
		end
		if (cmd.load_out) begin
			rsp <= '{rf_q[R_X], rf_q[R_G], rf_q[R_M], rf_q[R_OUR]};
		end
		if (cmd.start) begin
			op_q <= cmd.op;
			dst_q <= cmd.dst;
			a_q <= opa;
			b_q <= opb;
			mph_q <= '0;
			prod_q <= '0;
			if (cmd.op != OP_MUL && cmd.op != OP_DIV) rf_q[cmd.dst] <= res;
			num_q <= QW'(opa[31] ? -33'(opa) : 33'(opa)) << FRAC_BITS;
			den_q <= opb[31] ? 32'(-33'(opb)) : 32'(opb);
			dz_q <= (opb == 0);
			neg_q <= opa[31] ^ opb[31];
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= CW'(QW);
		end else if (busy_q && op_q == OP_MUL) begin
			mph_q <= mph_q + 2'd1;
			if (mph_q == 2'd0) prod_q <= 64'(a_q) * 64'($signed({1'b0, b_q[15:0]}));
			if (mph_q == 2'd1) prod_q <= prod_q + (64'(a_q) * 64'($signed(b_q[31:16])) <<< 16);
			if (mph_q == 2'd2) rf_q[dst_q] <= sat32(mq);
		end else if (busy_q && op_q == OP_DIV) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				num_q <= num_q << 1;
				if (rsh >= {1'b0, den_q}) begin
					rem_q <= rsh - {1'b0, den_q};
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					rem_q <= rsh;
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
			end else if (dz_q) begin
				rf_q[dst_q] <= a_q[31] ? 32'sh80000000 : 32'sh7FFFFFFF;
			end else begin
				rf_q[dst_q] <= sat32(neg_q ? -66'(quo_q) : 66'(quo_q));
			end
		end
	end

	assign sts.busy = busy_q;

endmodule

/* src/mgmi_control.sv */
// ----------------------------------------------------------------------------
// mgmi_control
// Sequencer that walks the micro-program of one request.
// ----------------------------------------------------------------------------
module mgmi_control
	import mgmi_pkg::*;
#(
	parameter int unsigned MAX_SUBSTEPS = DefMaxSubsteps
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [10:0] step_count,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input sts_t sts,
	output cmd_t cmd
);

	localparam int unsigned KW = $clog2(MAX_SUBSTEPS + 1) + 1;
	localparam logic [5:0] PcOur = 6'd0;
	localparam logic [5:0] PcStep = 6'd12;

	state_t state_q, state_d;
	logic [5:0] pc_q;
	logic [KW-1:0] k_q, n_q;
	logic step_phase_q;
	logic [KW-1:0] n_clamped;
	cmd_t uop;

	assign n_clamped = (KW'(step_count) > KW'(MAX_SUBSTEPS)) ? KW'(MAX_SUBSTEPS)
		: KW'(step_count);

	// Micro-program: uptake, oxygen rate, then rates at (x,g) or (xh,gh).
	always_comb begin
		src_t xs, gs;
		xs = step_phase_q ? S_XH : S_X;
		gs = step_phase_q ? S_GH : S_G;
		uop = '0;
		case (pc_q)
			6'd0, 6'd12: uop = '{1'b1, OP_ADD, (pc_q == 0) ? S_G : gs, S_KS, R_T0, 1'b0, 1'b0};
			6'd1, 6'd13: uop = '{1'b1, OP_DIV, (pc_q == 1) ? S_G : gs, S_T0, R_T0, 1'b0, 1'b0};
			6'd2, 6'd14: uop = '{1'b1, OP_ADD, S_O, S_KO, R_T1, 1'b0, 1'b0};
			6'd3, 6'd15: uop = '{1'b1, OP_DIV, S_O, S_T1, R_T1, 1'b0, 1'b0};
			6'd4, 6'd16: uop = '{1'b1, OP_MUL, S_QMAX, S_T0, R_Q, 1'b0, 1'b0};
			6'd5, 6'd17: uop = '{1'b1, OP_MUL, S_Q, S_T1, R_Q, 1'b0, 1'b0};
			6'd6: uop = '{1'b1, OP_MUL, S_OY, S_Q, R_OUR, 1'b0, 1'b0};
			6'd7: uop = '{1'b1, OP_MUL, S_OUR, S_X, R_OUR, 1'b0, 1'b0};
			6'd18: uop = '{1'b1, OP_DIV, xs, S_CAP, R_T0, 1'b0, 1'b0};
			6'd19: uop = '{1'b1, OP_SUB, S_ONE, S_T0, R_T0, 1'b0, 1'b0};
			6'd20: uop = '{1'b1, OP_MUL, S_BY, S_Q, R_RX, 1'b0, 1'b0};
			6'd21: uop = '{1'b1, OP_MUL, S_RX, xs, R_RX, 1'b0, 1'b0};
			6'd22: uop = '{1'b1, OP_MUL, S_RX, S_T0, R_RX, 1'b0, 1'b0};
			6'd23: uop = '{1'b1, OP_MUL, S_Q, xs, R_RG, 1'b0, 1'b0};
			6'd24: uop = '{1'b1, OP_NEG, S_RG, S_RG, R_RG, 1'b0, 1'b0};
			6'd25: uop = '{1'b1, OP_MUL, S_PY, S_Q, R_RM, 1'b0, 1'b0};
			6'd26: uop = '{1'b1, OP_MUL, S_RM, xs, R_RM, 1'b0, 1'b0};
			6'd27: uop = '{1'b1, OP_MUL, S_RX, S_DT, R_RX, 1'b0, 1'b0};
			6'd28: uop = '{1'b1, OP_MUL, S_RG, S_DT, R_RG, 1'b0, 1'b0};
			6'd29: uop = '{1'b1, OP_MUL, S_RM, S_DT, R_RM, 1'b0, 1'b0};
			6'd30: uop = step_phase_q ? '{1'b1, OP_ADD, S_X, S_RX, R_X, 1'b0, 1'b0}
				: '{1'b1, OP_ADDHALF, S_X, S_RX, R_XH, 1'b0, 1'b0};
			6'd31: uop = step_phase_q ? '{1'b1, OP_ADD, S_G, S_RG, R_G, 1'b0, 1'b0}
				: '{1'b1, OP_ADDHALF, S_G, S_RG, R_GH, 1'b0, 1'b0};
			6'd32: uop = step_phase_q ? '{1'b1, OP_ADD, S_M, S_RM, R_M, 1'b0, 1'b0}
				: '{1'b1, OP_ADDHALF, S_M, S_RM, R_MH, 1'b0, 1'b0};
			default: uop = '0;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_ISSUE;
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (!sts.busy) begin
					if (pc_q == 6'd7 && n_q == '0) state_d = ST_OUT;
					else if (pc_q == 6'd32 && step_phase_q && k_q + 1'b1 == n_q)
						state_d = ST_OUT;
					else state_d = ST_ISSUE;
				end
			end
			ST_OUT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_ISSUE: cmd = uop;
			ST_WAIT: cmd.load_out = !sts.busy && (state_d == ST_OUT);
			ST_OUT: out_valid = 1'b1;
			default: cmd = '0;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= PcOur;
			k_q <= '0;
			n_q <= '0;
			step_phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid) begin
				pc_q <= PcOur;
				k_q <= '0;
				n_q <= n_clamped;
				step_phase_q <= 1'b0;
			end else if (state_q == ST_WAIT && !sts.busy) begin
				if (pc_q == 6'd7) pc_q <= PcStep;
				else if (pc_q == 6'd32) begin
					pc_q <= PcStep;
					step_phase_q <= !step_phase_q;
					if (step_phase_q) k_q <= k_q + 1'b1;
				end else pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule

/* src/monod_growth_midpoint_integrator.sv */
// ----------------------------------------------------------------------------
// monod_growth_midpoint_integrator
// Monod uptake and midpoint integration of one cell per request.
// ----------------------------------------------------------------------------
// Usage: a request (in_valid, in_stall, in_data) carries biomass, oxygen,
// substrate, product and a substep count. The result (out_valid, out_stall,
// out_data) carries the advanced concentrations and the oxygen uptake rate.
// One request is processed at a time on one shared arithmetic unit that
// divides, multiplies and adds. An uptake prologue runs first and is
// followed by the substeps; the result is offered once the last substep
// is done, and the next request can be taken once the result is taken.
// Registers are to be written over the APB port only while idle; the
// block itself does not enforce this. Reset loads their defaults and
// clears the sequencer. A stalled result holds until taken; no new
// request is accepted while a result waits.
// ----------------------------------------------------------------------------
module monod_growth_midpoint_integrator
	import mgmi_pkg::*;
#(
	parameter int unsigned MAX_SUBSTEPS = DefMaxSubsteps,
	parameter int unsigned FRACTION_BITS = DefFracBits
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output rsp_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [AddrW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{RstTimeStep, RstBioYield, RstProdYield, RstOxyYield,
				RstCapacity, RstMaxUptake, RstOxyHalf, RstSubHalf};
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				RegTimeStep: cfg_q.time_step <= pwdata[30:0];
				RegBioYield: cfg_q.biomass_yield <= pwdata[30:0];
				RegProdYield: cfg_q.product_yield <= pwdata[30:0];
				RegOxyYield: cfg_q.oxygen_yield <= pwdata[30:0];
				RegCapacity: cfg_q.biomass_capacity <= pwdata[30:0];
				RegMaxUptake: cfg_q.max_uptake <= pwdata[30:0];
				RegOxyHalf: cfg_q.oxygen_half_saturation <= pwdata[30:0];
				RegSubHalf: cfg_q.substrate_half_saturation <= pwdata[30:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (ridx)
			RegTimeStep: prdata = {1'b0, cfg_q.time_step};
			RegBioYield: prdata = {1'b0, cfg_q.biomass_yield};
			RegProdYield: prdata = {1'b0, cfg_q.product_yield};
			RegOxyYield: prdata = {1'b0, cfg_q.oxygen_yield};
			RegCapacity: prdata = {1'b0, cfg_q.biomass_capacity};
			RegMaxUptake: prdata = {1'b0, cfg_q.max_uptake};
			RegOxyHalf: prdata = {1'b0, cfg_q.oxygen_half_saturation};
			RegSubHalf: prdata = {1'b0, cfg_q.substrate_half_saturation};
			default: prdata = '0;
		endcase
	end

	mgmi_control #(.MAX_SUBSTEPS(MAX_SUBSTEPS)) u_ctrl (
		.clk, .arst_n, .in_valid, .step_count(in_data.step_count), .in_stall,
		.out_valid, .out_stall, .sts, .cmd
	);

	mgmi_datapath #(.FRAC_BITS(FRACTION_BITS)) u_dp (
		.clk, .arst_n, .cmd, .req(in_data), .cfg(cfg_q), .sts, .rsp(out_data)
	);

endmodule

/* src/mgmi_checker.sv */
// ----------------------------------------------------------------------------
// mgmi_checker
// Port-level checks of the integrator's request and result channels and pready.
// ----------------------------------------------------------------------------
`include "monod_growth_midpoint_integrator_macros.svh"
module mgmi_checker
	import mgmi_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input rsp_t out_data,
	input logic pready
);

	`MGMI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "result dropped while stalled")
	`MGMI_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, out_valid, in_stall, "request accepted while result pending")
	`MGMI_ASSERT_NEXT(a_accept_blocks, clk, arst_n, in_valid && !in_stall, in_stall && !out_valid, "request not taken into work")
	`MGMI_ASSERT_IMPL(a_pready, clk, arst_n, 1'b1, pready, "pready low")

endmodule

bind monod_growth_midpoint_integrator mgmi_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data, .pready
);
